@@ sv/regional_sorted_queue_with_expiry_core_macros.svh @@
// ----------------------------------------------------------------------------
// regional sorted queue assertion macros
// shared property forms for the checker, sampled on clk with rst_n low as
// the disable condition
// ----------------------------------------------------------------------------
`ifndef REGIONAL_SORTED_QUEUE_WITH_EXPIRY_CORE_MACROS_SVH
`define REGIONAL_SORTED_QUEUE_WITH_EXPIRY_CORE_MACROS_SVH

// same-cycle implication
`define RSQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsq check failed");

// next-cycle implication
`define RSQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsq check failed");

`endif

@@ sv/rsq_pkg.sv @@
// ----------------------------------------------------------------------------
// rsq_pkg
// types, codes and field widths of the regional sorted queue
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int REQ_W    = 2;
    localparam int REGION_W = 3;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int EN_W     = 8;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [REGION_W-1:0] region_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [EN_W-1:0]     enable_t;

    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_QUERY  = 2'd1;
    localparam req_t REQ_EXPIRE = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    localparam count_t COUNT_MAX = 5'd31;

    typedef struct packed {
        region_t region;
        id_t     id;
        key_t    key;
        time_t   stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE      = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_INIT_INS  = 4'd2;
    localparam op_t OP_INIT_SCAN = 4'd3;
    localparam op_t OP_SET_NF    = 4'd4;
    localparam op_t OP_SET_FULL  = 4'd5;
    localparam op_t OP_SET_EMPTY = 4'd6;
    localparam op_t OP_INS_NEW   = 4'd7;
    localparam op_t OP_SHIFT     = 4'd8;
    localparam op_t OP_FOUND     = 4'd9;
    localparam op_t OP_NEXT      = 4'd10;
    localparam op_t OP_DROP      = 4'd11;
    localparam op_t OP_KEEP      = 4'd12;
    localparam op_t OP_EXP_DONE  = 4'd13;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        req_t req_type;
        logic region_ok;
        logic full;
        logic idx_zero;
        logic idx_end;
        logic shift_ok;
        logic match;
        logic expired;
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/rsq_req_if.sv @@
// ----------------------------------------------------------------------------
// rsq_req_if
// request channel: valid/ready with one request word
// ----------------------------------------------------------------------------
interface rsq_req_if;
    import rsq_pkg::*;

    logic    valid;
    logic    ready;
    req_t    req_type;
    region_t region;
    id_t     vehicle_id;
    key_t    fuel;
    time_t   now_time;
    time_t   max_age;

    modport source (
        output valid, req_type, region, vehicle_id, fuel, now_time, max_age,
        input  ready
    );

    modport sink (
        input  valid, req_type, region, vehicle_id, fuel, now_time, max_age,
        output ready
    );

endinterface

@@ sv/rsq_resp_if.sv @@
// ----------------------------------------------------------------------------
// rsq_resp_if
// response channel: valid/ready with one result word
// ----------------------------------------------------------------------------
interface rsq_resp_if;
    import rsq_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    id_t     found_id;
    key_t    found_fuel;
    count_t  removed_count;

    modport source (
        output valid, status, found_id, found_fuel, removed_count,
        input  ready
    );

    modport sink (
        input  valid, status, found_id, found_fuel, removed_count,
        output ready
    );

endinterface

@@ sv/rsq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rsq_cfg_if
// configuration write channel for the region enable register
// ----------------------------------------------------------------------------
interface rsq_cfg_if;
    import rsq_pkg::*;

    logic    valid;
    logic    ready;
    enable_t data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );

endinterface

@@ sv/regional_sorted_queue_with_expiry_core.sv @@
// insert moves each larger-keyed entry up one place, then writes the new entry
// query walks from the front to the first hit in its region; expire scans every entry
// one request at a time: the next is accepted only once the last response word is in
// the output register, so a stalled response also holds off new requests
// reset: rst_n clears the fill count, region enables and response valid at once;
// no clearing pass, the store is usable the cycle after reset is released
// ----------------------------------------------------------------------------
// regional_sorted_queue_with_expiry_core
// key-sorted bounded queue of per-region entries with query and age expiry
// ----------------------------------------------------------------------------
module regional_sorted_queue_with_expiry_core #(
    parameter int ENTRIES = 16,
    parameter int REGIONS = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    rsq_req_if.sink    req,
    rsq_resp_if.source resp,
    rsq_cfg_if.sink    cfg
);
    import rsq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    rsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsq_dp #(
        .ENTRIES (ENTRIES),
        .REGIONS (REGIONS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_req_type       (req.req_type),
        .in_region         (req.region),
        .in_vehicle_id     (req.vehicle_id),
        .in_fuel           (req.fuel),
        .in_now_time       (req.now_time),
        .in_max_age        (req.max_age),
        .cfg_valid         (cfg.valid),
        .cfg_data          (cfg.data),
        .out_valid         (resp.valid),
        .out_ready         (resp.ready),
        .out_status        (resp.status),
        .out_found_id      (resp.found_id),
        .out_found_fuel    (resp.found_fuel),
        .out_removed_count (resp.removed_count)
    );

endmodule

@@ sv/rsq_ram.sv @@
// ----------------------------------------------------------------------------
// rsq_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
module rsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/rsq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsq_ctrl
// request sequencer: dispatches insert, query and expire walks over the store
// ----------------------------------------------------------------------------
module rsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsq_pkg::dp_stat_t stat,
    output rsq_pkg::dp_cmd_t  cmd
);
    import rsq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority case (stat.req_type)
                    REQ_INSERT:
                    begin
                        priority if (!stat.region_ok)
                        begin
                            cmd.op     = OP_SET_NF;
                            state_next = S_FIN;
                        end
                        else if (stat.full)
                        begin
                            cmd.op     = OP_SET_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = OP_INIT_INS;
                            state_next = S_RD;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (!stat.region_ok)
                        begin
                            cmd.op     = OP_SET_NF;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = OP_INIT_SCAN;
                            state_next = S_RD;
                        end
                    end
                    REQ_EXPIRE:
                    begin
                        cmd.op     = OP_INIT_SCAN;
                        state_next = S_RD;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RD:
            begin
                if (stat.req_type == REQ_INSERT)
                begin
                    if (stat.idx_zero)
                    begin
                        cmd.op     = OP_INS_NEW;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
                else if (stat.idx_end)
                begin
                    cmd.op     = (stat.req_type == REQ_QUERY) ? OP_SET_EMPTY : OP_EXP_DONE;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.req_type == REQ_INSERT)
                begin
                    if (stat.shift_ok)
                    begin
                        cmd.op     = OP_SHIFT;
                        state_next = S_RD;
                    end
                    else
                    begin
                        cmd.op     = OP_INS_NEW;
                        state_next = S_FIN;
                    end
                end
                else if (stat.req_type == REQ_QUERY)
                begin
                    if (stat.match)
                    begin
                        cmd.op     = OP_FOUND;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    cmd.op     = stat.expired ? OP_DROP : OP_KEEP;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/rsq_dp.sv @@
// ----------------------------------------------------------------------------
// rsq_dp
// datapath: request word, walk pointers, fill count, entry store and result
// ----------------------------------------------------------------------------
module rsq_dp #(
    parameter int ENTRIES = 16,
    parameter int REGIONS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rsq_pkg::dp_cmd_t  cmd,
    output rsq_pkg::dp_stat_t stat,
    input  rsq_pkg::req_t     in_req_type,
    input  rsq_pkg::region_t  in_region,
    input  rsq_pkg::id_t      in_vehicle_id,
    input  rsq_pkg::key_t     in_fuel,
    input  rsq_pkg::time_t    in_now_time,
    input  rsq_pkg::time_t    in_max_age,
    input  logic              cfg_valid,
    input  rsq_pkg::enable_t  cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rsq_pkg::status_t  out_status,
    output rsq_pkg::id_t      out_found_id,
    output rsq_pkg::key_t     out_found_fuel,
    output rsq_pkg::count_t   out_removed_count
);
    import rsq_pkg::*;

    localparam int IDXW = $clog2(ENTRIES);
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(ENTRIES);
    localparam logic [CNTW-1:0] ONE      = CNTW'(1);
    localparam logic [7:0]      REG_LIM  = 8'(REGIONS);

    req_t            req_type_reg, req_type_next;
    region_t         region_reg, region_next;
    id_t             id_reg, id_next;
    key_t            key_reg, key_next;
    time_t           now_reg, now_next;
    time_t           max_age_reg, max_age_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] wr_reg, wr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    status_t         status_reg, status_next;
    id_t             fid_reg, fid_next;
    key_t            fkey_reg, fkey_next;
    count_t          removed_reg, removed_next;
    enable_t         en_reg, en_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    id_t             out_id_reg, out_id_next;
    key_t            out_fuel_reg, out_fuel_next;
    count_t          out_removed_reg, out_removed_next;

    logic            ram_we;
    logic [IDXW-1:0] ram_waddr;
    entry_t          ram_wdata;
    logic [IDXW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t          rd;
    logic [CNTW-1:0] idx_m1;
    time_t           age;

    assign rd     = entry_t'(ram_rdata);
    assign idx_m1 = idx_reg - ONE;
    assign age    = now_reg - rd.stamp;

    assign ram_raddr = (req_type_reg == REQ_INSERT) ? idx_m1[IDXW-1:0] : idx_reg[IDXW-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDXW-1:0];
        ram_wdata = rd;
        if (cmd.op == OP_INS_NEW)
        begin
            ram_we    = 1'b1;
            ram_wdata = '{region: region_reg, id: id_reg, key: key_reg, stamp: now_reg};
        end
        else if (cmd.op == OP_SHIFT)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.op == OP_KEEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_reg[IDXW-1:0];
        end
    end

    rsq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.req_type  = req_type_reg;
        stat.region_ok = ({5'd0, region_reg} < REG_LIM) && en_reg[region_reg];
        stat.full      = (cnt_reg == FULL_CNT);
        stat.idx_zero  = (idx_reg == '0);
        stat.idx_end   = (idx_reg == cnt_reg);
        stat.shift_ok  = (rd.key > key_reg);
        stat.match     = (rd.region == region_reg);
        stat.expired   = (age > max_age_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        req_type_next    = req_type_reg;
        region_next      = region_reg;
        id_next          = id_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        max_age_next     = max_age_reg;
        idx_next         = idx_reg;
        wr_next          = wr_reg;
        cnt_next         = cnt_reg;
        status_next      = status_reg;
        fid_next         = fid_reg;
        fkey_next        = fkey_reg;
        removed_next     = removed_reg;
        en_next          = cfg_valid ? cfg_data : en_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_fuel_next    = out_fuel_reg;
        out_removed_next = out_removed_reg;

        unique case (cmd.op)
            OP_LOAD:
            begin
                req_type_next = in_req_type;
                region_next   = in_region;
                id_next       = in_vehicle_id;
                key_next      = in_fuel;
                now_next      = in_now_time;
                max_age_next  = in_max_age;
                status_next   = ST_OK;
                fid_next      = '0;
                fkey_next     = '0;
                removed_next  = '0;
            end
            OP_INIT_INS:  idx_next = cnt_reg;
            OP_INIT_SCAN:
            begin
                idx_next = '0;
                wr_next  = '0;
            end
            OP_SET_NF:    status_next = ST_NOT_FOUND;
            OP_SET_FULL:  status_next = ST_FULL;
            OP_SET_EMPTY: status_next = ST_EMPTY;
            OP_INS_NEW:   cnt_next = cnt_reg + ONE;
            OP_SHIFT:     idx_next = idx_m1;
            OP_FOUND:
            begin
                fid_next  = rd.id;
                fkey_next = rd.key;
            end
            OP_NEXT:      idx_next = idx_reg + ONE;
            OP_DROP:
            begin
                idx_next = idx_reg + ONE;
                if (removed_reg != COUNT_MAX)
                begin
                    removed_next = removed_reg + 5'd1;
                end
            end
            OP_KEEP:
            begin
                idx_next = idx_reg + ONE;
                wr_next  = wr_reg + ONE;
            end
            OP_EXP_DONE:  cnt_next = wr_reg;
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = status_reg;
            out_id_next      = fid_reg;
            out_fuel_next    = fkey_reg;
            out_removed_next = removed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg    <= req_type_next;
        region_reg      <= region_next;
        id_reg          <= id_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        max_age_reg     <= max_age_next;
        idx_reg         <= idx_next;
        wr_reg          <= wr_next;
        status_reg      <= status_next;
        fid_reg         <= fid_next;
        fkey_reg        <= fkey_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_fuel_reg    <= out_fuel_next;
        out_removed_reg <= out_removed_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_found_id      = out_id_reg;
    assign out_found_fuel    = out_fuel_reg;
    assign out_removed_count = out_removed_reg;

endmodule

@@ sv/rsq_checker.sv @@
// ----------------------------------------------------------------------------
// rsq_checker
// port-level checks on the request and response channels
// ----------------------------------------------------------------------------
`include "regional_sorted_queue_with_expiry_core_macros.svh"

module rsq_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic             resp_valid,
    input  logic             resp_ready,
    input  rsq_pkg::status_t resp_status,
    input  rsq_pkg::id_t     resp_found_id,
    input  rsq_pkg::key_t    resp_found_fuel,
    input  rsq_pkg::count_t  resp_removed_count
);
    import rsq_pkg::*;

    `RSQ_ASSERT_NXT(a_resp_hold, resp_valid && !resp_ready, resp_valid && $stable(resp_status) && $stable(resp_found_id) && $stable(resp_found_fuel) && $stable(resp_removed_count))
    `RSQ_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
    `RSQ_ASSERT_IMP(a_err_zero, resp_valid && (resp_status != ST_OK), (resp_found_id == '0) && (resp_found_fuel == '0) && (resp_removed_count == '0))
    `RSQ_ASSERT_IMP(a_removed_ok, resp_valid && (resp_removed_count != '0), (resp_status == ST_OK) && (resp_found_id == '0) && (resp_found_fuel == '0))

endmodule

bind regional_sorted_queue_with_expiry_core rsq_checker u_rsq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .resp_valid         (resp.valid),
    .resp_ready         (resp.ready),
    .resp_status        (resp.status),
    .resp_found_id      (resp.found_id),
    .resp_found_fuel    (resp.found_fuel),
    .resp_removed_count (resp.removed_count)
);

@@ test/rsq_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rsq_tb_pkg
// prediction and scoreboard for the regional sorted queue: keeps its own
// key-sorted entry store and region enables, works out the answer of every
// accepted request and compares each returned word field by field
// ----------------------------------------------------------------------------
package rsq_tb_pkg;
    import rsq_pkg::*;

    localparam int   STORE_DEPTH  = 16;
    localparam int   REGION_COUNT = 8;
    localparam req_t REQ_UNUSED   = 2'd3;

    typedef struct packed {
        status_t status;
        id_t     id;
        key_t    key;
        count_t  removed;
    } answer_t;

    class sorted_queue_scoreboard;
        entry_t  cells[$];
        answer_t answers[$];
        enable_t enables;
        int      errors;
        int      checked;

        function new();
            enables = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void note_enables(enable_t value);
            enables = value;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function bit region_live(region_t r);
            return (int'(r) < REGION_COUNT) && enables[r];
        endfunction

        function void note_request(req_t kind, region_t r, id_t id, key_t key,
                                   time_t now, time_t max_age);
            answer_t     a;
            entry_t      e;
            entry_t      kept[$];
            time_t       age;
            int          pos;
            int unsigned gone;
            a    = '0;
            gone = 0;
            case (kind)
                REQ_INSERT:
                begin
                    if (!region_live(r))
                        a.status = ST_NOT_FOUND;
                    else if (cells.size() >= STORE_DEPTH)
                        a.status = ST_FULL;
                    else
                    begin
                        // new entry goes after every entry with lower or equal key
                        pos = 0;
                        while (pos < cells.size() && cells[pos].key <= key)
                            pos++;
                        e.region = r;
                        e.id     = id;
                        e.key    = key;
                        e.stamp  = now;
                        cells.insert(pos, e);
                    end
                end
                REQ_QUERY:
                begin
                    if (!region_live(r))
                        a.status = ST_NOT_FOUND;
                    else
                    begin
                        a.status = ST_EMPTY;
                        for (int i = 0; i < cells.size() && a.status == ST_EMPTY; i++)
                        begin
                            if (cells[i].region == r)
                            begin
                                a.status = ST_OK;
                                a.id     = cells[i].id;
                                a.key    = cells[i].key;
                            end
                        end
                    end
                end
                REQ_EXPIRE:
                begin
                    // age wraps modulo 2^32, all regions scanned
                    foreach (cells[i])
                    begin
                        age = now - cells[i].stamp;
                        if (age > max_age)
                            gone++;
                        else
                            kept.push_back(cells[i]);
                    end
                    cells     = kept;
                    a.removed = (gone > COUNT_MAX) ? COUNT_MAX : count_t'(gone);
                end
                default:
                begin
                end
            endcase
            answers.push_back(a);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", what);
        endtask

        task check_response(status_t status, id_t id, key_t key, count_t removed);
            answer_t a;
            checked++;
            if (answers.size() == 0)
            begin
                report($sformatf("word %0d arrived with no request waiting", checked));
                return;
            end
            a = answers.pop_front();
            if (status !== a.status)
                report($sformatf("word %0d status %0d, want %0d", checked, status, a.status));
            if (id !== a.id)
                report($sformatf("word %0d found_id %h, want %h", checked, id, a.id));
            if (key !== a.key)
                report($sformatf("word %0d found_fuel %h, want %h", checked, key, a.key));
            if (removed !== a.removed)
                report($sformatf("word %0d removed_count %0d, want %0d",
                                 checked, removed, a.removed));
        endtask
    endclass

endpackage

@@ test/regional_sorted_queue_with_expiry_core_tb.sv @@
// ----------------------------------------------------------------------------
// regional_sorted_queue_with_expiry_core_tb
// drives inserts, queries, expiries and unused codes under several region
// enable settings with random gaps on both channels, and checks every
// response word against the scoreboard's own sorted store
// ----------------------------------------------------------------------------
module regional_sorted_queue_with_expiry_core_tb;
    import rsq_pkg::*;
    import rsq_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    IDLE_LIMIT  = 3000;
    localparam int    TAIL_CYCLES = 40;
    localparam time_t AGE_LIMIT_S = 32'd3600;

    logic clk;
    logic rst_n;
    bit   calm;
    int   idle_cycles;
    time_t sim_now;

    sorted_queue_scoreboard queue_pred;

    rsq_req_if  req_ch();
    rsq_resp_if resp_ch();
    rsq_cfg_if  cfg_ch();

    regional_sorted_queue_with_expiry_core #(
        .ENTRIES(STORE_DEPTH),
        .REGIONS(REGION_COUNT)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .resp (resp_ch),
        .cfg  (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // response checked before the request of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (resp_ch.valid && resp_ch.ready)
                queue_pred.check_response(resp_ch.status, resp_ch.found_id,
                                          resp_ch.found_fuel, resp_ch.removed_count);
            if (req_ch.valid && req_ch.ready)
                queue_pred.note_request(req_ch.req_type, req_ch.region, req_ch.vehicle_id,
                                        req_ch.fuel, req_ch.now_time, req_ch.max_age);
            if (cfg_ch.valid && cfg_ch.ready)
                queue_pred.note_enables(cfg_ch.data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : resp_side
        int stall;
        resp_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                resp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            resp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!resp_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic issue_request(req_t kind, region_t r, id_t id, key_t key,
                                 time_t now, time_t max_age);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.region     <= r;
        req_ch.vehicle_id <= id;
        req_ch.fuel       <= key;
        req_ch.now_time   <= now;
        req_ch.max_age    <= max_age;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (queue_pred.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_enables(enable_t value);
        wait_drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_request();
        int    pick;
        req_t  kind;
        key_t  key;
        time_t now;
        time_t max_age;
        pick    = $urandom_range(0, 99);
        sim_now = sim_now + $urandom_range(0, 600);
        now     = ($urandom_range(0, 31) == 0) ? time_t'($urandom()) : sim_now;
        // narrow keys give plenty of ties
        if ($urandom_range(0, 1) == 1)
            key = key_t'($urandom());
        else
            key = key_t'($urandom_range(0, 7) * 256);
        case ($urandom_range(0, 3))
            0, 1: max_age = time_t'($urandom_range(0, 3600));
            2: max_age = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: max_age = time_t'($urandom());
        endcase
        if (pick < 50)
            kind = REQ_INSERT;
        else if (pick < 80)
            kind = REQ_QUERY;
        else if (pick < 95)
            kind = REQ_EXPIRE;
        else
            kind = REQ_UNUSED;
        issue_request(kind, region_t'($urandom_range(0, 7)), id_t'($urandom()), key,
                      now, max_age);
    endtask

    initial
    begin : stimulus
        enable_t setting;
        rst_n             = 1'b0;
        calm              = 1'b0;
        sim_now           = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_INSERT;
        req_ch.region     = '0;
        req_ch.vehicle_id = '0;
        req_ch.fuel       = '0;
        req_ch.now_time   = '0;
        req_ch.max_age    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        queue_pred        = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // nothing enabled after reset
        issue_request(REQ_INSERT, 3'd0, 16'h1234, 16'h0100, 32'd0, 32'd0);
        issue_request(REQ_QUERY, 3'd7, 16'h0000, 16'h0000, 32'd0, 32'd0);
        write_enables(8'hFF);
        issue_request(REQ_QUERY, 3'd3, 16'h0000, 16'h0000, 32'd0, 32'd0);
        issue_request(REQ_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // key and id extremes, then equal keys in arrival order
        issue_request(REQ_INSERT, 3'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        issue_request(REQ_INSERT, 3'd1, 16'h0000, 16'h0000, 32'd0, 32'd0);
        issue_request(REQ_INSERT, 3'd0, 16'h0001, 16'h0100, 32'd10, 32'd0);
        issue_request(REQ_INSERT, 3'd0, 16'h0002, 16'h0100, 32'd20, 32'd0);
        issue_request(REQ_QUERY, 3'd0, 16'h0000, 16'h0000, 32'd0, 32'd0);
        for (int i = 0; i < 12; i++)
            issue_request(REQ_INSERT, region_t'(i % 8), id_t'(16'h0100 + i), 16'h8000,
                          32'd0, 32'd0);
        issue_request(REQ_INSERT, 3'd2, 16'hBEEF, 16'h0001, 32'd0, 32'd0);
        // disabled region while full: not found wins, entries stay
        write_enables(8'hFE);
        issue_request(REQ_INSERT, 3'd0, 16'h5555, 16'h0001, 32'd0, 32'd0);
        issue_request(REQ_QUERY, 3'd0, 16'h0000, 16'h0000, 32'd0, 32'd0);
        // wrapped ages, then everything older than zero seconds
        issue_request(REQ_EXPIRE, 3'd5, 16'h0000, 16'h0000, 32'd5, AGE_LIMIT_S);
        issue_request(REQ_EXPIRE, 3'd0, 16'h0000, 16'h0000, 32'd1, 32'd0);
        issue_request(REQ_QUERY, 3'd1, 16'h0000, 16'h0000, 32'd0, 32'd0);

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
                setting = 8'hFF;
            else if (phase == 1)
                setting = 8'h00;
            else
                setting = enable_t'($urandom_range(0, 255));
            calm = (phase % 4 == 2);
            write_enables(setting);
            for (int n = 0; n < 150; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drain();
                random_request();
            end
        end

        calm = 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (queue_pred.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/rsq_pkg.sv
sv/rsq_req_if.sv
sv/rsq_resp_if.sv
sv/rsq_cfg_if.sv
sv/rsq_ram.sv
sv/rsq_ctrl.sv
sv/rsq_dp.sv
sv/regional_sorted_queue_with_expiry_core.sv
sv/rsq_checker.sv
test/rsq_tb_pkg.sv
test/regional_sorted_queue_with_expiry_core_tb.sv
